// ===== rtl/tvm_pkg.sv =====
// Shared types, codes and sizes of the toy VM execute block.
// Used by tvm_div and toy_vm_instruction_execute; depends on nothing.
`timescale 1ns / 1ps

package tvm_pkg;

  localparam int REG_COUNT   = 16;
  localparam int MEM_WORDS   = 1024;
  localparam int LABEL_SLOTS = 64;

  localparam int WORD_W = 32;
  localparam int PC_W   = 16;
  localparam int LBL_W  = 16;

  localparam int REG_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int LBL_AW = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;
  localparam int LCNT_W = $clog2(LABEL_SLOTS + 1);
  localparam int CLR_N  = (REG_COUNT > MEM_WORDS) ? REG_COUNT : MEM_WORDS;
  localparam int CLR_W  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam int DIV_CW = $clog2(WORD_W) + 1;

  typedef enum logic [3:0] {
    OP_HALT = 4'd0,  OP_MOV = 4'd1,  OP_ADD = 4'd2,  OP_SUB = 4'd3,
    OP_MUL  = 4'd4,  OP_DIV = 4'd5,  OP_CMP = 4'd6,  OP_JMP = 4'd7,
    OP_JZ   = 4'd8,  OP_JNZ = 4'd9,  OP_JG  = 4'd10, OP_JL  = 4'd11,
    OP_JGE  = 4'd12, OP_JLE = 4'd13, OP_LEA = 4'd14, OP_DEFL = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    K_REG = 2'd0, K_IMM = 2'd1, K_MEM = 2'd2, K_LBL = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_DIV0 = 3'd1, E_LABEL = 3'd2,
    E_DEST = 3'd3, E_LEA = 3'd4, E_INDEX = 3'd5
  } err_t;

  localparam logic [1:0] FLAG_NONE = 2'd0;
  localparam logic [1:0] FLAG_EQ   = 2'd1;
  localparam logic [1:0] FLAG_GT   = 2'd2;
  localparam logic [1:0] FLAG_LT   = 2'd3;

  typedef struct packed {
    err_t              err;
    logic [WORD_W-1:0] val;
  } opnd_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ===== rtl/tvm_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on tvm_pkg.
`timescale 1ns / 1ps

module tvm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tvm_pkg::WORD_W-1:0]    a,
  input  logic [tvm_pkg::WORD_W-1:0]    b,
  output logic                          done,
  output logic [tvm_pkg::WORD_W-1:0]    q
);
  import tvm_pkg::*;

  logic              busy_r, done_r, neg_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [WORD_W-1:0] rem_r, quo_r, den_r;
  logic [WORD_W:0]   rem_sh, diff;

  assign rem_sh = {rem_r, quo_r[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CW'(WORD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[WORD_W-1] ^ b[WORD_W-1];
      quo_r <= a[WORD_W-1] ? (~a + 1'b1) : a;
      den_r <= b[WORD_W-1] ? (~b + 1'b1) : b;
      rem_r <= '0;
    end else if (busy_r) begin
      // keep the shifted remainder when the trial subtraction goes negative
      if (!diff[WORD_W]) begin
        rem_r <= diff[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign q    = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== rtl/toy_vm_instruction_execute.sv =====
// Instruction-execute core of a small two-operand VM: register file, data memory,
// label table, program counter, compare flag and stop mark. Depends on tvm_pkg, tvm_div.
`timescale 1ns / 1ps

// After reset the block sweeps its data memory and register file to zero, one word
// a cycle, over max(REG_COUNT, MEM_WORDS) addresses, before it takes the first
// item. Then each instruction has one step for the synchronous operand reads of
// the register file, data memory and label table, and one to compute and write back.
// A divide also waits on the bit-serial divider. One item is in flight at a time;
// a finished result waits in the output register while the next item is taken.
module toy_vm_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[3:0], first_value[35:4], second_value[67:36], zeros[71:68]
  input  logic [71:0] in_tdata,
  // first_kind[1:0], has_second[2], second_kind[4:3]
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_pc[16:0], flag_state[18:17], wrote_value[50:19], halted[51],
  // error_code[54:52], zero[55]
  output logic [55:0] out_tdata
);
  import tvm_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_DIV} state_t;

  state_t             state_r;
  logic [CLR_W-1:0]   clr_r;
  op_t                op_r;
  kind_t              k1_r, k2_r;
  logic [WORD_W-1:0]  v1_r, v2_r;
  logic [PC_W-1:0]    pc_r;
  logic [1:0]         flag_r;
  logic               stop_r;
  logic [LCNT_W-1:0]  lcnt_r;
  logic               out_tvalid_r;
  logic [55:0]        out_tdata_r;

  logic [WORD_W-1:0]  rf_mem [REG_COUNT];
  logic [WORD_W-1:0]  dm_mem [MEM_WORDS];
  logic [LBL_W-1:0]   lt_mem [LABEL_SLOTS];
  logic [WORD_W-1:0]  rf_a_r, rf_b_r, dm_a_r, dm_b_r;
  logic [LBL_W-1:0]   lt_a_r, lt_b_r;

  op_t                in_op;
  kind_t              in_k1, in_k2;
  logic [WORD_W-1:0]  in_v1, in_v2;
  logic               accept, slot_free, clearing, commit, div_go;

  opnd_t              opa, opb;
  err_t               err;
  logic [WORD_W-1:0]  res, wrote, mul_lo;
  logic               writes, lt_we, stop_n;
  logic [PC_W-1:0]    pc_n, pc_inc;
  logic [1:0]         flag_n;
  logic [LCNT_W-1:0]  lcnt_n;
  logic [16:0]        next_pc;
  div_ctl_t           div_ctl;
  logic [WORD_W-1:0]  div_q;

  function automatic opnd_t read_opnd(kind_t k, logic [WORD_W-1:0] v,
                                      logic [WORD_W-1:0] rf, logic [WORD_W-1:0] dm,
                                      logic [LBL_W-1:0] lt, logic [LCNT_W-1:0] lcnt);
    opnd_t o;
    o.err = E_NONE;
    o.val = '0;
    case (k)
      K_REG: begin
        if (v >= WORD_W'(REG_COUNT)) o.err = E_INDEX;
        else o.val = rf;
      end
      K_IMM: o.val = v;
      K_MEM: begin
        if (v >= WORD_W'(MEM_WORDS)) o.err = E_INDEX;
        else o.val = dm;
      end
      default: begin
        if (v >= WORD_W'(lcnt)) o.err = E_LABEL;
        else o.val = WORD_W'(lt);
      end
    endcase
    return o;
  endfunction

  function automatic err_t check_dest(kind_t k, logic [WORD_W-1:0] v);
    err_t e;
    case (k)
      K_REG:   e = (v < WORD_W'(REG_COUNT)) ? E_NONE : E_INDEX;
      K_MEM:   e = (v < WORD_W'(MEM_WORDS)) ? E_NONE : E_INDEX;
      default: e = E_DEST;
    endcase
    return e;
  endfunction

  function automatic logic jump_taken(op_t op, logic [1:0] f);
    logic t;
    case (op)
      OP_JMP:  t = 1'b1;
      OP_JZ:   t = (f == FLAG_EQ);
      OP_JNZ:  t = (f != FLAG_EQ);
      OP_JG:   t = (f == FLAG_GT);
      OP_JL:   t = (f == FLAG_LT);
      OP_JGE:  t = (f == FLAG_GT) || (f == FLAG_EQ);
      default: t = (f == FLAG_LT) || (f == FLAG_EQ);
    endcase
    return t;
  endfunction

  // ---- input decode; an absent second operand reads as immediate zero
  assign in_op  = op_t'(in_tdata[3:0]);
  assign in_v1  = in_tdata[35:4];
  assign in_k1  = kind_t'(in_tuser[1:0]);
  assign in_k2  = in_tuser[2] ? kind_t'(in_tuser[4:3]) : K_IMM;
  assign in_v2  = in_tuser[2] ? in_tdata[67:36] : '0;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign clearing  = (state_r == S_CLEAR);

  // ---- memories: registered reads at accept, writes at commit or during the sweep
  always_ff @(posedge clk) begin
    if (accept) begin
      rf_a_r <= rf_mem[in_v1[REG_AW-1:0]];
      rf_b_r <= rf_mem[in_v2[REG_AW-1:0]];
    end
    if (clearing && ({1'b0, clr_r} < (CLR_W+1)'(REG_COUNT)))
      rf_mem[clr_r[REG_AW-1:0]] <= '0;
    else if (commit && writes && (k1_r == K_REG))
      rf_mem[v1_r[REG_AW-1:0]] <= res;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dm_a_r <= dm_mem[in_v1[MEM_AW-1:0]];
      dm_b_r <= dm_mem[in_v2[MEM_AW-1:0]];
    end
    if (clearing && ({1'b0, clr_r} < (CLR_W+1)'(MEM_WORDS)))
      dm_mem[clr_r[MEM_AW-1:0]] <= '0;
    else if (commit && writes && (k1_r == K_MEM))
      dm_mem[v1_r[MEM_AW-1:0]] <= res;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lt_a_r <= lt_mem[in_v1[LBL_AW-1:0]];
      lt_b_r <= lt_mem[in_v2[LBL_AW-1:0]];
    end
    if (commit && lt_we)
      lt_mem[v1_r[LBL_AW-1:0]] <= v2_r[LBL_W-1:0];
  end

  // ---- execute
  assign opa    = read_opnd(k1_r, v1_r, rf_a_r, dm_a_r, lt_a_r, lcnt_r);
  assign opb    = read_opnd(k2_r, v2_r, rf_b_r, dm_b_r, lt_b_r, lcnt_r);
  assign mul_lo = opa.val * opb.val;
  assign pc_inc = pc_r + 1'b1;

  always_comb begin
    err    = E_NONE;
    res    = '0;
    writes = 1'b0;
    lt_we  = 1'b0;
    pc_n   = pc_r;
    flag_n = flag_r;
    stop_n = stop_r;
    lcnt_n = lcnt_r;
    if (!stop_r) begin
      case (op_r)
        OP_HALT: stop_n = 1'b1;
        OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
          if (op_r != OP_MOV) err = opa.err;
          if (err == E_NONE) err = opb.err;
          if ((err == E_NONE) && (op_r == OP_DIV) && (opb.val == '0)) err = E_DIV0;
          if ((err == E_NONE) && (op_r != OP_CMP)) err = check_dest(k1_r, v1_r);
          if (err == E_NONE) begin
            case (op_r)
              OP_MOV: res = opb.val;
              OP_ADD: res = opa.val + opb.val;
              OP_SUB: res = opa.val - opb.val;
              OP_MUL: res = mul_lo;
              OP_DIV: res = div_q;
              default: begin
                if (opa.val == opb.val) flag_n = FLAG_EQ;
                else if ($signed(opa.val) > $signed(opb.val)) flag_n = FLAG_GT;
                else flag_n = FLAG_LT;
              end
            endcase
            writes = (op_r != OP_CMP);
            pc_n   = pc_inc;
          end
        end
        OP_LEA: begin
          if (k2_r == K_LBL) err = E_LEA;
          else if (k2_r == K_REG) begin
            err = opb.err;
            res = opb.val;
          end else res = v2_r;
          if (err == E_NONE) err = check_dest(k1_r, v1_r);
          if (err == E_NONE) begin
            writes = 1'b1;
            pc_n   = pc_inc;
          end
        end
        OP_DEFL: begin
          if (v1_r >= WORD_W'(LABEL_SLOTS)) err = E_INDEX;
          else begin
            lt_we = 1'b1;
            if (v1_r >= WORD_W'(lcnt_r)) lcnt_n = LCNT_W'(v1_r + 1'b1);
          end
        end
        default: begin
          if (jump_taken(op_r, flag_r)) begin
            if (v1_r >= WORD_W'(lcnt_r)) err = E_LABEL;
            else pc_n = PC_W'(lt_a_r);
          end else pc_n = pc_inc;
        end
      endcase
      if (err != E_NONE) stop_n = 1'b1;
    end
  end

  assign wrote   = writes ? res : '0;
  assign next_pc = stop_n ? '1 : {1'b0, pc_n};

  assign div_go  = (state_r == S_EXEC) && (op_r == OP_DIV) && !stop_r && (err == E_NONE);
  assign commit  = slot_free && (((state_r == S_EXEC) && !div_go) ||
                                 ((state_r == S_DIV) && div_ctl.done));

  assign div_ctl.start = div_go;

  tvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_ctl.start),
    .a     (opa.val),
    .b     (opb.val),
    .done  (div_ctl.done),
    .q     (div_q)
  );

  // ---- sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      pc_r         <= '0;
      flag_r       <= FLAG_NONE;
      stop_r       <= 1'b0;
      lcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLR_W'(CLR_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (accept) state_r <= S_EXEC;
        S_EXEC: if (div_go) state_r <= S_DIV;
                else if (commit) state_r <= S_IDLE;
        S_DIV:  if (commit) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (commit) begin
        pc_r         <= pc_n;
        flag_r       <= flag_n;
        stop_r       <= stop_n;
        lcnt_r       <= lcnt_n;
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {1'b0, err, stop_n, wrote, flag_n, next_pc};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      k1_r <= in_k1;
      v1_r <= in_v1;
      k2_r <= in_k2;
      v2_r <= in_v2;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r) else $error("stop mark cleared");
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[51]) |-> (out_tdata_r[16:0] == '1))
    else $error("halted result without pc of -1");
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tdata_r[54:52] != E_NONE)) |-> out_tdata_r[51])
    else $error("error without halt");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (op_r == OP_DIV))
    else $error("divider wait on a non-divide item");
`endif

endmodule

// ===== tb/tvm_exec_checker.sv =====
// Checker for the toy VM execute block: predicts each result from the accepted
// instructions and compares it with the block's output. Depends on tvm_pkg.
`timescale 1ns / 1ps

module tvm_exec_checker
  import tvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [4:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [16:0] next_pc;
    logic [1:0]  flag;
    logic [31:0] wrote;
    logic        halted;
    logic [2:0]  err;
  } outcome_t;

  logic [31:0] vm_regs [REG_COUNT];
  logic [31:0] vm_mem  [MEM_WORDS];
  logic [15:0] vm_lbl  [LABEL_SLOTS];
  int unsigned vm_lbl_cnt;
  logic [15:0] vm_pc;
  logic [1:0]  vm_flag;
  logic        vm_stopped;
  outcome_t    outcome_q [$];

  function automatic err_t fetch(kind_t k, logic [31:0] v, output logic [31:0] val);
    val = '0;
    case (k)
      K_REG: begin
        if (v >= REG_COUNT) return E_INDEX;
        val = vm_regs[v];
      end
      K_IMM: val = v;
      K_MEM: begin
        if (v >= MEM_WORDS) return E_INDEX;
        val = vm_mem[v];
      end
      default: begin
        if (v >= vm_lbl_cnt) return E_LABEL;
        val = {16'h0, vm_lbl[v]};
      end
    endcase
    return E_NONE;
  endfunction

  function automatic err_t dest_ok(kind_t k, logic [31:0] v);
    if (k == K_REG) return (v < REG_COUNT) ? E_NONE : E_INDEX;
    if (k == K_MEM) return (v < MEM_WORDS) ? E_NONE : E_INDEX;
    return E_DEST;
  endfunction

  function automatic outcome_t execute_instr(op_t op, kind_t k1, logic [31:0] v1,
                                             logic h2, kind_t k2, logic [31:0] v2);
    err_t        e;
    logic [31:0] a, b, r;
    logic        wr, taken;
    outcome_t    res;
    e = E_NONE; a = '0; b = '0; r = '0; wr = 1'b0; taken = 1'b0;
    if (!h2) begin
      k2 = K_IMM;
      v2 = '0;
    end
    if (!vm_stopped) begin
      case (op)
        OP_HALT: vm_stopped = 1'b1;
        OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
          if (op != OP_MOV) e = fetch(k1, v1, a);
          if (e == E_NONE) e = fetch(k2, v2, b);
          if (e == E_NONE && op == OP_DIV && b == 0) e = E_DIV0;
          if (e == E_NONE && op != OP_CMP) e = dest_ok(k1, v1);
          if (e == E_NONE) begin
            case (op)
              OP_MOV: r = b;
              OP_ADD: r = a + b;
              OP_SUB: r = a - b;
              OP_MUL: r = a * b;
              OP_DIV: begin
                // minimum over -1 wraps back to the minimum
                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = a;
                else r = $signed(a) / $signed(b);
              end
              default: begin
                if (a == b) vm_flag = FLAG_EQ;
                else if ($signed(a) > $signed(b)) vm_flag = FLAG_GT;
                else vm_flag = FLAG_LT;
              end
            endcase
            wr    = (op != OP_CMP);
            vm_pc = vm_pc + 16'd1;
          end
        end
        OP_LEA: begin
          if (k2 == K_LBL) e = E_LEA;
          else if (k2 == K_REG) e = fetch(K_REG, v2, r);
          else r = v2;
          if (e == E_NONE) e = dest_ok(k1, v1);
          if (e == E_NONE) begin
            wr    = 1'b1;
            vm_pc = vm_pc + 16'd1;
          end
        end
        OP_DEFL: begin
          if (v1 >= LABEL_SLOTS) e = E_INDEX;
          else begin
            vm_lbl[v1] = v2[15:0];
            if (v1 + 1 > vm_lbl_cnt) vm_lbl_cnt = v1 + 1;
          end
        end
        default: begin
          case (op)
            OP_JMP: taken = 1'b1;
            OP_JZ:  taken = (vm_flag == FLAG_EQ);
            OP_JNZ: taken = (vm_flag != FLAG_EQ);
            OP_JG:  taken = (vm_flag == FLAG_GT);
            OP_JL:  taken = (vm_flag == FLAG_LT);
            OP_JGE: taken = (vm_flag == FLAG_GT || vm_flag == FLAG_EQ);
            default: taken = (vm_flag == FLAG_LT || vm_flag == FLAG_EQ);
          endcase
          if (!taken) vm_pc = vm_pc + 16'd1;
          else if (v1 >= vm_lbl_cnt) e = E_LABEL;
          else vm_pc = vm_lbl[v1];
        end
      endcase
      if (e != E_NONE) vm_stopped = 1'b1;
      else if (wr) begin
        if (k1 == K_REG) vm_regs[v1] = r;
        else vm_mem[v1] = r;
      end
    end
    res.next_pc = vm_stopped ? 17'h1FFFF : {1'b0, vm_pc};
    res.flag    = vm_flag;
    res.wrote   = (e == E_NONE && wr) ? r : '0;
    res.halted  = vm_stopped;
    res.err     = e;
    return res;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $realtime, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      // clear the model along with the block
      fail_count = 0;
      pending    = 0;
      foreach (vm_regs[i]) vm_regs[i] = '0;
      foreach (vm_mem[i]) vm_mem[i] = '0;
      foreach (vm_lbl[i]) vm_lbl[i] = '0;
      vm_lbl_cnt = 0;
      vm_pc      = '0;
      vm_flag    = FLAG_NONE;
      vm_stopped = 1'b0;
      outcome_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        outcome_q.push_back(execute_instr(op_t'(in_tdata[3:0]), kind_t'(in_tuser[1:0]),
                                          in_tdata[35:4], in_tuser[2],
                                          kind_t'(in_tuser[4:3]), in_tdata[67:36]));
        pending++;
      end
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result item with nothing outstanding", $realtime);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          pending--;
          if (out_tdata[16:0] !== want.next_pc)
            report("next_pc", 32'(out_tdata[16:0]), 32'(want.next_pc));
          if (out_tdata[18:17] !== want.flag)
            report("flag_state", 32'(out_tdata[18:17]), 32'(want.flag));
          if (out_tdata[50:19] !== want.wrote)
            report("wrote_value", out_tdata[50:19], want.wrote);
          if (out_tdata[51] !== want.halted)
            report("halted", 32'(out_tdata[51]), 32'(want.halted));
          if (out_tdata[54:52] !== want.err)
            report("error_code", 32'(out_tdata[54:52]), 32'(want.err));
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for toy_vm_instruction_execute: clock, reset, instruction stimulus
// and verdict. Depends on tvm_pkg, the block and tvm_exec_checker.
`timescale 1ns / 1ps

module tb_top;
  import tvm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  int          fail_count, pending;
  int          snd_idle = 0, rcv_stall = 0;
  int unsigned lbl_cnt = 0;
  int          cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  toy_vm_instruction_execute u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  tvm_exec_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(negedge clk) out_tready <= ($urandom_range(99) >= rcv_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic push_instr(op_t op, kind_t k1, logic [31:0] v1, bit h2, kind_t k2,
                            logic [31:0] v2);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {4'h0, v2, v1, op};
    in_tuser  <= {k2, h2, k1};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (op == OP_DEFL && v1 < LABEL_SLOTS && v1 + 1 > lbl_cnt) lbl_cnt = v1 + 1;
  endtask

  function automatic logic [31:0] loc(kind_t k);
    if (k == K_REG) return $urandom_range(0, REG_COUNT - 1);
    return ($urandom_range(0, 9) == 0) ? MEM_WORDS - 1 : $urandom_range(0, 15);
  endfunction

  // well-formed instruction: never stops the machine
  task automatic random_instr();
    int          sel;
    op_t         op;
    kind_t       k1, k2;
    logic [31:0] v1, v2;
    bit          h2;
    sel = $urandom_range(0, 99);
    h2  = ($urandom_range(0, 9) != 0);
    k1  = $urandom_range(0, 1) ? K_MEM : K_REG;
    v1  = loc(k1);
    k2  = kind_t'($urandom_range(0, lbl_cnt > 0 ? 3 : 2));
    if (k2 == K_IMM) v2 = $urandom;
    else if (k2 == K_LBL) v2 = $urandom_range(0, lbl_cnt - 1);
    else v2 = loc(k2);
    if (sel < 8) begin
      op = OP_DEFL;
      v1 = $urandom_range(0, lbl_cnt < LABEL_SLOTS - 1 ? lbl_cnt : LABEL_SLOTS - 1);
      k1 = kind_t'($urandom_range(0, 3));
      v2 = $urandom;
      h2 = 1'b1;
    end else if (sel < 30 && lbl_cnt > 0) begin
      op = op_t'($urandom_range(OP_JMP, OP_JLE));
      k1 = kind_t'($urandom_range(0, 3));
      v1 = $urandom_range(0, lbl_cnt - 1);
    end else if (sel < 40) begin
      op = OP_LEA;
      k2 = kind_t'($urandom_range(0, 2));
      v2 = (k2 == K_REG) ? loc(K_REG) : $urandom;
    end else begin
      op = op_t'($urandom_range(OP_MOV, OP_CMP));
      if (op == OP_CMP) begin
        k1 = kind_t'($urandom_range(0, lbl_cnt > 0 ? 3 : 2));
        if (k1 == K_IMM) v1 = $urandom;
        else if (k1 == K_LBL) v1 = $urandom_range(0, lbl_cnt - 1);
        else v1 = loc(k1);
      end
      if (op == OP_DIV) begin
        h2 = 1'b1;
        if (k2 == K_LBL) k2 = K_IMM;
        if (k2 == K_IMM) begin
          if (v2 == 0) v2 = 32'd1;
          if ($urandom_range(0, 3) == 0) v2 = $urandom_range(1, 9) * ($urandom_range(0, 1) ? 1 : -1);
        end else begin
          // seed the divisor location with a non-zero value first
          push_instr(OP_MOV, k2, v2, 1'b1, K_IMM, $urandom_range(1, 1000) | $urandom);
        end
      end
    end
    push_instr(op, k1, v1, h2, k2, v2);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every operation but HALT, wrap cases
    push_instr(OP_DEFL, K_IMM, 0, 1, K_IMM, 32'hFFFF_FFFF);
    push_instr(OP_DEFL, K_REG, 1, 1, K_REG, 32'h0001_0000);
    push_instr(OP_MOV, K_REG, 15, 1, K_IMM, 32'h7FFF_FFFF);
    push_instr(OP_ADD, K_REG, 15, 1, K_IMM, 32'd1);
    push_instr(OP_MOV, K_MEM, MEM_WORDS - 1, 1, K_IMM, 32'h8000_0000);
    push_instr(OP_DIV, K_MEM, MEM_WORDS - 1, 1, K_IMM, 32'hFFFF_FFFF);
    push_instr(OP_MUL, K_REG, 15, 1, K_MEM, MEM_WORDS - 1);
    push_instr(OP_SUB, K_REG, 0, 1, K_LBL, 0);
    push_instr(OP_CMP, K_IMM, 32'h8000_0000, 1, K_IMM, 32'h7FFF_FFFF);
    push_instr(OP_JL, K_IMM, 1, 0, K_IMM, 0);
    push_instr(OP_JG, K_REG, 0, 0, K_IMM, 0);
    push_instr(OP_CMP, K_LBL, 0, 1, K_IMM, 32'h0000_FFFF);
    push_instr(OP_JZ, K_LBL, 1, 0, K_IMM, 0);
    push_instr(OP_JNZ, K_LBL, 1, 0, K_IMM, 0);
    push_instr(OP_CMP, K_IMM, 32'h7FFF_FFFF, 1, K_REG, 15);
    push_instr(OP_JGE, K_MEM, 1, 0, K_IMM, 0);
    push_instr(OP_JLE, K_MEM, 1, 0, K_IMM, 0);
    push_instr(OP_JMP, K_REG, 0, 0, K_IMM, 0);
    push_instr(OP_MOV, K_REG, 1, 0, K_REG, 0);
    push_instr(OP_LEA, K_MEM, 5, 1, K_MEM, 32'hFFFF_FFFF);
    push_instr(OP_LEA, K_REG, 2, 1, K_REG, 15);
    push_instr(OP_LEA, K_REG, 3, 1, K_IMM, 32'h8000_0000);
    push_instr(OP_MOV, K_REG, 4, 1, K_IMM, 32'hFFFF_FFF3);
    push_instr(OP_DIV, K_REG, 4, 1, K_IMM, 32'd5);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 83; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 83; end
        default: begin snd_idle = 15; rcv_stall = 15; end
      endcase
      for (int i = 0; i < 300; i++) begin
        random_instr();
        if (ph == 2 && i == 150) begin
          // hold off until the block has drained
          @(negedge clk);
          in_tvalid <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
      end
    end

    // one stopping case per run, then items the stopped machine must ignore
    case ($urandom_range(0, 6))
      0: push_instr(OP_HALT, K_REG, 0, 0, K_REG, 0);
      1: push_instr(OP_DIV, K_REG, 3, 1, K_IMM, 0);
      2: push_instr(OP_JMP, K_LBL, $urandom_range(0, 1) ? lbl_cnt : 32'hFFFF_FFFF, 0, K_IMM, 0);
      3: push_instr(OP_MOV, $urandom_range(0, 1) ? K_IMM : K_LBL, 0, 1, K_IMM, 32'd9);
      4: push_instr(OP_LEA, K_REG, 2, 1, K_LBL, 0);
      5: push_instr(OP_ADD, K_REG, $urandom_range(0, 1) ? 32'hFFFF_FFFF : REG_COUNT,
                    1, K_IMM, 1);
      default: push_instr(OP_DEFL, K_IMM, LABEL_SLOTS, 1, K_IMM, 32'd7);
    endcase
    for (int i = 0; i < 3; i++)
      push_instr(op_t'($urandom_range(0, 15)), kind_t'($urandom_range(0, 3)), $urandom,
                 $urandom_range(0, 1), kind_t'($urandom_range(0, 3)), $urandom);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
